// ----- rtl/gtg_pkg.sv -----
`timescale 1ns / 1ps

package gtg_pkg;

  // CORDIC setup
  localparam int CORDIC_STEPS = 16;
  localparam int AtanLen      = 24;
  localparam int CordicIters  = (CORDIC_STEPS > AtanLen) ? AtanLen : CORDIC_STEPS;

  // Vector words: dx/dy scaled by 2^14 plus CORDIC growth; angle in Q2.30 with headroom
  localparam int VecW = 34;
  localparam int AngW = 35;

  localparam logic signed [AngW-1:0] PiQ30   = 35'sd3373259426;
  localparam logic [15:0]            GainK16 = 16'd39797;

  // Request to result, in cycles
  localparam int Latency = CordicIters + 5;

  // Register map
  typedef enum logic [1:0] {
    CfgLinearGain  = 2'd0,
    CfgAngularGain = 2'd1,
    CfgArriveTol   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] pose_heading;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
  } pose_req_t;

  typedef struct packed {
    logic        [18:0] fwd_vel;
    logic signed [19:0] yaw_rate;
    logic               reached;
  } speed_cmd_t;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
  } cordic_vec_t;

  // atan(2^-i) in Q2.30
  function automatic logic signed [AngW-1:0] atan_q30(input int unsigned idx);
    logic signed [AngW-1:0] v;
    unique case (idx)
      0:  v = 35'sd843314856;
      1:  v = 35'sd497837829;
      2:  v = 35'sd263043836;
      3:  v = 35'sd133525158;
      4:  v = 35'sd67021686;
      5:  v = 35'sd33543515;
      6:  v = 35'sd16775850;
      7:  v = 35'sd8388437;
      8:  v = 35'sd4194282;
      9:  v = 35'sd2097149;
      10: v = 35'sd1048575;
      11: v = 35'sd524287;
      12: v = 35'sd262143;
      13: v = 35'sd131071;
      14: v = 35'sd65535;
      15: v = 35'sd32767;
      16: v = 35'sd16383;
      17: v = 35'sd8191;
      18: v = 35'sd4095;
      19: v = 35'sd2047;
      20: v = 35'sd1023;
      21: v = 35'sd511;
      22: v = 35'sd255;
      23: v = 35'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/go_to_goal_p_controller.sv -----
`timescale 1ns / 1ps

// Go-to-goal P controller. A request (pose and goal point) is taken at every
// rising edge with start_i high; busy_o stays low, so one request per cycle is
// sustained. The result is strobed on res_o by res_valid_o for one cycle. It
// passes through the goal-offset stage, the CORDIC vectoring pipe (one
// iteration per stage), then the gain and angle rounding, distance rounding
// and heading error, speed scaling and output rounding stages, in order. The
// receiver cannot stall and must take every strobed result. Gain and
// tolerance registers are written through the cfg port (always ready) and
// should only change while no request is in flight.
module go_to_goal_p_controller import gtg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  pose_req_t  req_i,
  output logic       res_valid_o,
  output speed_cmd_t res_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers
  logic [15:0] lin_gain_q, ang_gain_q, arrive_tol_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_gain_q   <= 16'd6554;
      ang_gain_q   <= 16'd1792;
      arrive_tol_q <= 16'd5;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgLinearGain:  lin_gain_q   <= cfg_data_i;
        CfgAngularGain: ang_gain_q   <= cfg_data_i;
        CfgArriveTol:   arrive_tol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage A: goal offset
  logic               a_vld_q;
  logic signed [16:0] a_dx_q, a_dy_q;
  logic signed [15:0] a_hd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    a_dx_q <= 17'(req_i.goal_x) - 17'(req_i.pose_x);
    a_dy_q <= 17'(req_i.goal_y) - 17'(req_i.pose_y);
    a_hd_q <= req_i.pose_heading;
  end

  // Half-plane fold into the right half, angle preset to +/- pi
  cordic_vec_t        fold_vec;
  logic signed [VecW-1:0] sx, sy;

  assign sx = {{3{a_dx_q[16]}}, a_dx_q, 14'd0};
  assign sy = {{3{a_dy_q[16]}}, a_dy_q, 14'd0};

  always_comb begin
    if (a_dx_q < 0) begin
      fold_vec.x = -sx;
      fold_vec.y = -sy;
      fold_vec.z = (a_dy_q >= 0) ? PiQ30 : -PiQ30;
    end else begin
      fold_vec.x = sx;
      fold_vec.y = sy;
      fold_vec.z = '0;
    end
  end

  logic               c_vld;
  cordic_vec_t        c_vec;
  logic signed [15:0] c_hd;

  gtg_cordic u_cordic (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (a_vld_q),
    .in_vec_i     (fold_vec),
    .in_heading_i (a_hd_q),
    .out_valid_o  (c_vld),
    .out_vec_o    (c_vec),
    .out_heading_o(c_hd)
  );

  // Stage M: gain-compensate magnitude, round angle to Q3.12
  logic               m_vld_q;
  logic [48:0]        m_prod_q;
  logic signed [17:0] m_bear_q;
  logic signed [15:0] m_hd_q;
  logic [32:0]        x_pos;
  logic signed [35:0] z_rnd;

  assign x_pos = c_vec.x[VecW-1] ? '0 : c_vec.x[32:0];
  assign z_rnd = 36'(c_vec.z) + 36'sd131072;

  // Stage N: round distance, heading error
  logic               n_vld_q;
  logic [19:0]        n_dist_q;
  logic signed [18:0] n_diff_q;
  logic [49:0]        dist_rnd;

  assign dist_rnd = 50'(m_prod_q) + 50'd536870912;

  // Stage P: scale both speeds, tolerance check
  logic               p_vld_q;
  logic               p_reach_q;
  logic [35:0]        p_lin_q;
  logic signed [35:0] p_ang_q;
  logic signed [16:0] ang_gain_s;

  assign ang_gain_s = $signed({1'b0, ang_gain_q});

  // Stage Q: round, saturate, output
  logic               q_vld_q;
  speed_cmd_t         q_res_q;
  speed_cmd_t         res_d;
  logic [36:0]        lin_rnd;
  logic signed [36:0] ang_rnd;
  logic [24:0]        lin_val;
  logic signed [28:0] ang_val;

  assign lin_rnd = 37'(p_lin_q) + 37'd2048;
  assign ang_rnd = 37'(p_ang_q) + 37'sd128;
  assign lin_val = lin_rnd[36:12];
  assign ang_val = ang_rnd[36:8];

  always_comb begin
    res_d = '0;
    if (p_reach_q) begin
      res_d.reached = 1'b1;
    end else begin
      res_d.fwd_vel  = (lin_val > 25'd524287) ? 19'h7FFFF : lin_val[18:0];
      if (ang_val > 29'sd524287) begin
        res_d.yaw_rate = 20'sd524287;
      end else if (ang_val < -29'sd524288) begin
        res_d.yaw_rate = -20'sd524288;
      end else begin
        res_d.yaw_rate = ang_val[19:0];
      end
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      n_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
      q_vld_q <= 1'b0;
    end else begin
      m_vld_q <= c_vld;
      n_vld_q <= m_vld_q;
      p_vld_q <= n_vld_q;
      q_vld_q <= p_vld_q;
    end
  end

  // data path
  always_ff @(posedge clk_i) begin
    m_prod_q  <= 49'(x_pos) * 49'(GainK16);
    m_bear_q  <= z_rnd[35:18];
    m_hd_q    <= c_hd;
    n_dist_q  <= dist_rnd[49:30];
    n_diff_q  <= 19'(m_bear_q) - 19'(m_hd_q);
    p_reach_q <= n_dist_q <= 20'(arrive_tol_q);
    p_lin_q   <= 36'(lin_gain_q) * 36'(n_dist_q);
    p_ang_q   <= 36'(n_diff_q) * 36'(ang_gain_s);
    q_res_q   <= res_d;
  end

  assign res_valid_o = q_vld_q;
  assign res_o       = q_res_q;

  // every request yields one result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency res_valid_o)
    else $error("request did not produce a result on time");

  // a result only ever follows a request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_o) |-> $past(start_i, Latency))
    else $error("result without request");

  // reached forces both speeds to zero
  a_reached_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.reached) |->
      (res_o.fwd_vel == '0 && res_o.yaw_rate == '0))
    else $error("speeds nonzero at goal");

endmodule

// ----- rtl/gtg_cordic.sv -----
`timescale 1ns / 1ps

module gtg_cordic import gtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  cordic_vec_t        in_vec_i,
  input  logic signed [15:0] in_heading_i,
  output logic               out_valid_o,
  output cordic_vec_t        out_vec_o,
  output logic signed [15:0] out_heading_o
);

  // One vectoring iteration per register stage
  logic               vld_q [CordicIters];
  cordic_vec_t        vec_q [CordicIters];
  logic signed [15:0] hd_q  [CordicIters];

  for (genvar i = 0; i < CordicIters; i++) begin : g_stage
    logic               vld_in;
    cordic_vec_t        vec_in;
    logic signed [15:0] hd_in;
    cordic_vec_t        vec_d;

    if (i == 0) begin : g_first
      assign vld_in = in_valid_i;
      assign vec_in = in_vec_i;
      assign hd_in  = in_heading_i;
    end else begin : g_next
      assign vld_in = vld_q[i-1];
      assign vec_in = vec_q[i-1];
      assign hd_in  = hd_q[i-1];
    end

    // rotate toward the x axis; >>> floors
    always_comb begin
      if (vec_in.y > 0) begin
        vec_d.x = vec_in.x + (vec_in.y >>> i);
        vec_d.y = vec_in.y - (vec_in.x >>> i);
        vec_d.z = vec_in.z + atan_q30(i);
      end else begin
        vec_d.x = vec_in.x - (vec_in.y >>> i);
        vec_d.y = vec_in.y + (vec_in.x >>> i);
        vec_d.z = vec_in.z - atan_q30(i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      vec_q[i] <= vec_d;
      hd_q[i]  <= hd_in;
    end
  end

  assign out_valid_o   = vld_q[CordicIters-1];
  assign out_vec_o     = vec_q[CordicIters-1];
  assign out_heading_o = hd_q[CordicIters-1];

  // valid passes through every stage register before it leaves
  a_stage_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> ##CordicIters out_valid_o)
    else $error("cordic valid lost in pipe");

endmodule
